>>> rtl/core/btpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy tree page allocator package
// Shared sizes, codes, transaction payloads and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package btpa_pkg;

    localparam int PAGES      = 128;
    localparam int LOG_PAGES  = $clog2(PAGES);
    localparam int TREE_NODES = 2 * PAGES - 1;
    // Node numbers run from 1; entry 0 of the store is never used.
    localparam int TREE_SIZE  = TREE_NODES + 1;
    localparam int NODE_W     = LOG_PAGES + 1;
    localparam int LOG_W      = $clog2(LOG_PAGES + 1);
    localparam int TZ_W       = $clog2(NODE_W + 1);
    localparam int COUNT_W    = 8;
    localparam int PAGE_W     = 7;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BAD_REQ = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_PART  = 2'd1,
        MARK_FULL  = 2'd2
    } t_mark;

    typedef struct packed {
        t_op                  operation;
        logic [COUNT_W-1:0]   page_count;
        logic [PAGE_W-1:0]    given_page;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [PAGE_W-1:0]    block_start;
    } t_rsp;

    typedef struct packed {
        logic load_req;    // capture and check a new request
        logic seek_init;   // start the depth-first search at the root
        logic free_init;   // clear the node of the block being freed
        logic rd_sib;      // read the sibling instead of the current node
        logic descend;     // step to the left child
        logic advance;     // step to the next node in depth-first order
        logic mark;        // mark the current node full and record its start
        logic climb;       // write the recomputed parent and move up
        logic res_ok;
        logic res_no_free;
        logic res_bad;
        logic load_out;    // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic is_free;
        logic at_target;
        logic rd_full;
        logic rd_empty;
        logic no_next;
        logic at_root;
        logic out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/core/btpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy tree page allocator controller
// Sequences request checking, the depth-first search, the ancestor update
// and the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module btpa_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire btpa_pkg::t_dp_status  i_status,
    output btpa_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_CHECK     = 7'b0000010,
        S_SEEK_RD   = 7'b0000100,
        S_SEEK_EVAL = 7'b0001000,
        S_CLIMB_RD  = 7'b0010000,
        S_CLIMB_WR  = 7'b0100000,
        S_FINISH    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.bad) begin
                    o_cmd.res_bad = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_status.is_free) begin
                    o_cmd.free_init = 1'b1;
                    n_state         = S_CLIMB_RD;
                end else begin
                    o_cmd.seek_init = 1'b1;
                    n_state         = S_SEEK_RD;
                end
            end
            S_SEEK_RD: begin
                n_state = S_SEEK_EVAL;
            end
            S_SEEK_EVAL: begin
                // A full node, or a used node of the wanted size, ends this branch.
                if (i_status.rd_full || (i_status.at_target && !i_status.rd_empty)) begin
                    if (i_status.no_next) begin
                        o_cmd.res_no_free = 1'b1;
                        n_state           = S_FINISH;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_SEEK_RD;
                    end
                end else if (i_status.at_target) begin
                    o_cmd.mark = 1'b1;
                    n_state    = S_CLIMB_RD;
                end else begin
                    o_cmd.descend = 1'b1;
                    n_state       = S_SEEK_RD;
                end
            end
            S_CLIMB_RD: begin
                if (i_status.at_root) begin
                    o_cmd.res_ok = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.rd_sib = 1'b1;
                    n_state      = S_CLIMB_WR;
                end
            end
            S_CLIMB_WR: begin
                o_cmd.climb = 1'b1;
                n_state     = S_CLIMB_RD;
            end
            S_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/btpa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy tree page allocator datapath
// Holds the node mark store, the search pointer, the request and result
// registers and the output register.
// ----------------------------------------------------------------------------
module btpa_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire btpa_pkg::t_req        i_req,
    input  wire btpa_pkg::t_dp_cmd     i_cmd,
    output btpa_pkg::t_dp_status       o_status,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output btpa_pkg::t_rsp             o_out_data
);

    // Request registers.
    btpa_pkg::t_op                        r_op;
    logic [btpa_pkg::PAGE_W-1:0]          r_page;
    logic [btpa_pkg::LOG_W-1:0]           r_log_size;
    logic                                 r_bad;
    logic [btpa_pkg::LOG_W-1:0]           n_log_size;
    logic                                 n_bad;
    logic [btpa_pkg::COUNT_W:0]           pow;
    logic [btpa_pkg::PAGE_W-1:0]          page_mask;
    logic                                 count_bad;

    // Walk registers.
    logic [btpa_pkg::NODE_W-1:0]          r_node;
    logic [btpa_pkg::LOG_W-1:0]           r_depth;
    btpa_pkg::t_mark                      r_val;
    logic [btpa_pkg::LOG_W-1:0]           want_depth;
    logic [btpa_pkg::NODE_W-1:0]          free_node;
    logic [btpa_pkg::NODE_W:0]            nxt_raw;
    logic [btpa_pkg::TZ_W-1:0]            tz;
    logic [btpa_pkg::NODE_W-1:0]          nxt_node;
    logic [btpa_pkg::NODE_W-1:0]          offset;
    btpa_pkg::t_mark                      parent_val;

    // Node mark store with a valid bit per entry; an unwritten node is empty.
    logic [1:0]                           r_tree [btpa_pkg::TREE_SIZE];
    logic [btpa_pkg::TREE_SIZE-1:0]       r_node_vld;
    logic [1:0]                           r_rd_data;
    logic                                 r_rd_vld;
    btpa_pkg::t_mark                      rd_mark;
    logic [btpa_pkg::NODE_W-1:0]          rd_addr;
    logic [btpa_pkg::NODE_W-1:0]          wr_addr;
    btpa_pkg::t_mark                      wr_data;
    logic                                 wr_en;

    // Result and output registers.
    btpa_pkg::t_status                    r_res_status;
    logic [btpa_pkg::PAGE_W-1:0]          r_res_start;
    logic                                 r_out_valid;
    btpa_pkg::t_rsp                       r_out_data;

    // Request decode: smallest power of two that covers the page count.
    always_comb begin
        n_log_size = '0;
        pow        = '0;
        for (int k = btpa_pkg::LOG_PAGES; k >= 0; k--) begin
            pow = (btpa_pkg::COUNT_W + 1)'(1) << k;
            if (pow >= {1'b0, i_req.page_count}) begin
                n_log_size = btpa_pkg::LOG_W'(k);
            end
        end
        count_bad = (i_req.page_count == '0) ||
                    (i_req.page_count > btpa_pkg::COUNT_W'(btpa_pkg::PAGES));
        page_mask = ~({btpa_pkg::PAGE_W{1'b1}} << n_log_size);
        n_bad     = count_bad ||
                    ((i_req.operation == btpa_pkg::OP_FREE) &&
                     ((i_req.given_page & page_mask) != '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op       <= i_req.operation;
            r_page     <= i_req.given_page;
            r_log_size <= n_log_size;
            r_bad      <= n_bad;
        end
    end

    assign want_depth = btpa_pkg::LOG_W'(btpa_pkg::LOG_PAGES) - r_log_size;
    assign free_node  = (btpa_pkg::NODE_W'(1) << want_depth) |
                        (btpa_pkg::NODE_W'(r_page) >> r_log_size);

    // Next node in depth-first order: add one, then climb past the right
    // children that the carry ran through.
    always_comb begin
        nxt_raw = {1'b0, r_node} + (btpa_pkg::NODE_W + 1)'(1);
        tz      = '0;
        for (int i = btpa_pkg::NODE_W; i >= 0; i--) begin
            if (nxt_raw[i]) begin
                tz = btpa_pkg::TZ_W'(i);
            end
        end
        nxt_node = btpa_pkg::NODE_W'(nxt_raw >> tz);
    end

    assign offset = r_node ^ (btpa_pkg::NODE_W'(1) << r_depth);

    assign rd_mark = r_rd_vld ? btpa_pkg::t_mark'(r_rd_data) : btpa_pkg::MARK_EMPTY;

    always_comb begin
        if ((r_val == btpa_pkg::MARK_FULL) && (rd_mark == btpa_pkg::MARK_FULL)) begin
            parent_val = btpa_pkg::MARK_FULL;
        end else if ((r_val == btpa_pkg::MARK_EMPTY) && (rd_mark == btpa_pkg::MARK_EMPTY)) begin
            parent_val = btpa_pkg::MARK_EMPTY;
        end else begin
            parent_val = btpa_pkg::MARK_PART;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seek_init) begin
            r_node  <= btpa_pkg::NODE_W'(1);
            r_depth <= '0;
        end else if (i_cmd.free_init) begin
            r_node  <= free_node;
            r_depth <= want_depth;
            r_val   <= btpa_pkg::MARK_EMPTY;
        end else if (i_cmd.descend) begin
            r_node  <= r_node << 1;
            r_depth <= r_depth + btpa_pkg::LOG_W'(1);
        end else if (i_cmd.advance) begin
            r_node  <= nxt_node;
            r_depth <= r_depth - btpa_pkg::LOG_W'(tz);
        end else if (i_cmd.mark) begin
            r_val   <= btpa_pkg::MARK_FULL;
        end else if (i_cmd.climb) begin
            r_node  <= r_node >> 1;
            r_depth <= r_depth - btpa_pkg::LOG_W'(1);
            r_val   <= parent_val;
        end
    end

    // Store ports.
    assign rd_addr = i_cmd.rd_sib ? (r_node ^ btpa_pkg::NODE_W'(1)) : r_node;

    always_comb begin
        wr_en   = i_cmd.free_init || i_cmd.mark || i_cmd.climb;
        wr_addr = r_node;
        wr_data = btpa_pkg::MARK_FULL;
        if (i_cmd.free_init) begin
            wr_addr = free_node;
            wr_data = btpa_pkg::MARK_EMPTY;
        end else if (i_cmd.climb) begin
            wr_addr = r_node >> 1;
            wr_data = parent_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tree[wr_addr] <= wr_data;
        end
        r_rd_data <= r_tree[rd_addr];
        r_rd_vld  <= r_node_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_vld <= '0;
        end else if (wr_en) begin
            r_node_vld[wr_addr] <= 1'b1;
        end
    end

    // Result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_res_start <= '0;
        end else if (i_cmd.mark) begin
            r_res_start <= btpa_pkg::PAGE_W'(offset << r_log_size);
        end
        if (i_cmd.res_bad) begin
            r_res_status <= btpa_pkg::ST_BAD_REQ;
        end else if (i_cmd.res_no_free) begin
            r_res_status <= btpa_pkg::ST_NO_FREE;
        end else if (i_cmd.res_ok) begin
            r_res_status <= btpa_pkg::ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.status      <= r_res_status;
            r_out_data.block_start <= r_res_start;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_status.bad       = r_bad;
        o_status.is_free   = (r_op == btpa_pkg::OP_FREE);
        o_status.at_target = (r_depth == want_depth);
        o_status.rd_full   = (rd_mark == btpa_pkg::MARK_FULL);
        o_status.rd_empty  = (rd_mark == btpa_pkg::MARK_EMPTY);
        o_status.no_next   = ((nxt_raw & (nxt_raw - (btpa_pkg::NODE_W + 1)'(1))) == '0);
        o_status.at_root   = (r_node == btpa_pkg::NODE_W'(1));
        o_status.out_busy  = r_out_valid && i_out_stall;
    end

endmodule
`default_nettype wire

>>> rtl/core/buddy_tree_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy tree page allocator
// Allocates and frees power-of-two blocks of pages over a binary tree of
// node marks (empty, partly full, full).
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_in_valid / o_in_stall / i_in_data; each request
//   produces exactly one response transaction on o_out_valid / i_out_stall /
//   o_out_data. One request is worked on at a time: o_in_stall is high from
//   the cycle after a request is taken until its response has been placed in
//   the output register.
//   Timing is set by the registered read of the node store: each tree
//   node visited takes a read and an evaluate state, and each ancestor
//   updated takes a read and a write state.
//     bad request : checked, then handed to the output register
//     free        : climbs from the freed node to the root
//     allocate    : depth-first search, backtracking over the tree as
//                   needed, then a climb from the marked node to the root.
//   The output register lets a finished response wait while the next request
//   is taken; a stalled response holds, and a later result waits in the
//   controller until the output register frees up.
//   Reset clears the per-node valid bits at once, so every node reads as
//   empty right after reset and no clearing pass is needed.
// ----------------------------------------------------------------------------
module buddy_tree_page_allocator (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire btpa_pkg::t_req   i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output btpa_pkg::t_rsp        o_out_data
);

    btpa_pkg::t_dp_cmd    cmd;
    btpa_pkg::t_dp_status status;

    btpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    btpa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

>>> rtl/core/btpa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy tree page allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module btpa_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire btpa_pkg::t_req   i_in_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire btpa_pkg::t_rsp   o_out_data
);

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while a previous one is in flight");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != btpa_pkg::ST_DONE)) |->
        (o_out_data.block_start == '0))
        else $error("block start set on a failed request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled response changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule

bind buddy_tree_page_allocator btpa_checker u_btpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
